// ----- hdl/pdfe_pkg.sv -----
package pdfe_pkg;

   localparam int FRAME_BYTES_DEF = 17;
   localparam int BYTE_W          = 8;
   localparam int IDX_W           = 5;
   localparam int WORD_W          = 32;
   localparam int CHIP_W          = 16;
   localparam int CHIP_LEN_W      = 5;
   localparam int ACC_W           = 24;
   localparam int ACC_CNT_W       = 5;
   localparam int NIB_CNT_W       = 4;
   localparam int PREAMBLE_BYTES  = 3;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [BYTE_W-1:0]    SYNC_BYTE  = 8'h5D;
   localparam logic [CHIP_W-1:0]    TAIL_CHIPS = 16'h8000;
   localparam logic [NIB_CNT_W-1:0] NIB_TAIL   = 4'd8;
   localparam logic [NIB_CNT_W-1:0] NIB_DONE   = 4'd9;

   typedef struct packed {
      logic [CHIP_W-1:0]     chips;
      logic [CHIP_LEN_W-1:0] len;
   } chips_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] word;
   } word_req_type;

   // expand four bits, MSB first: one -> 1000, zero -> 10; chips left aligned
   function automatic chips_type nibble_chips(input logic [3:0] nib);
      chips_type             r;
      logic [CHIP_LEN_W-1:0] pos;
      r.chips = '0;
      pos     = '0;
      for (int i = 3; i >= 0; i--) begin
         r.chips = r.chips | (TAIL_CHIPS >> pos);
         if (nib[i]) begin
            pos = pos + CHIP_LEN_W'(4);
         end else begin
            pos = pos + CHIP_LEN_W'(2);
         end
      end
      r.len = pos;
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] preamble_byte(input logic [1:0] idx);
      logic [BYTE_W-1:0] b;
      unique case (idx)
         2'd0:    b = 8'hFF;
         2'd1:    b = 8'hFF;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ----- hdl/pdfe_front.sv -----
module pdfe_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // pin [7:0], command [15:8]
   output pdfe_pkg::word_req_type        q_out,
   input  logic                          q_ready
);

   localparam int PTR_W = (pdfe_pkg::QUEUE_DEPTH > 1) ? $clog2(pdfe_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(pdfe_pkg::QUEUE_DEPTH + 1);

   logic [pdfe_pkg::WORD_W-1:0] mem_ff [pdfe_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [7:0]                  pin_rev;
   logic [7:0]                  command;
   logic [pdfe_pkg::WORD_W-1:0] word;
   logic                        push;
   logic                        pop;

   always_comb begin
      command = req_tdata[15:8];
      for (int i = 0; i < 8; i++) begin
         pin_rev[i] = req_tdata[7-i];
      end
      word = {pdfe_pkg::SYNC_BYTE, pin_rev, command, ~command};
   end

   assign req_tready  = (count_ff != CNT_W'(pdfe_pkg::QUEUE_DEPTH));
   assign push        = req_tvalid && req_tready;
   assign q_out.valid = (count_ff != '0);
   assign q_out.word  = mem_ff[rd_ptr_ff];
   assign pop         = q_out.valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(pdfe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(pdfe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

// ----- hdl/pdfe_back.sv -----
module pdfe_back #(
   parameter int FRAME_BYTES = pdfe_pkg::FRAME_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pdfe_pkg::word_req_type        q_in,
   output logic                          q_ready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // frame_byte [7:0], byte_index [12:8]
   output logic                          rsp_tlast
);

   localparam logic [pdfe_pkg::IDX_W-1:0] LAST_IDX = pdfe_pkg::IDX_W'(FRAME_BYTES - 1);

   logic                                active_ff, active_in;
   logic [pdfe_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic [pdfe_pkg::WORD_W-1:0]         word_ff, word_in;
   logic [pdfe_pkg::NIB_CNT_W-1:0]      nib_ff, nib_in;
   logic [pdfe_pkg::ACC_W-1:0]          acc_ff, acc_in;
   logic [pdfe_pkg::ACC_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                                out_valid_ff, out_valid_in;
   logic [pdfe_pkg::BYTE_W-1:0]         out_byte_ff;
   logic [pdfe_pkg::IDX_W-1:0]          out_idx_ff;
   logic                                out_last_ff;

   logic                                step;
   logic                                is_last;
   logic                                load;
   logic                                need_fill;
   pdfe_pkg::chips_type                 src;
   logic [pdfe_pkg::ACC_W-1:0]          merged;
   logic [pdfe_pkg::ACC_CNT_W-1:0]      merged_cnt;
   logic [pdfe_pkg::BYTE_W-1:0]         byte_out;

   assign step      = active_ff && (!out_valid_ff || rsp_tready);
   assign is_last   = (idx_ff == LAST_IDX);
   assign load      = q_in.valid && (!active_ff || (step && is_last));
   assign q_ready   = load;
   assign need_fill = (cnt_ff < pdfe_pkg::ACC_CNT_W'(8));

   always_comb begin
      if (nib_ff < pdfe_pkg::NIB_TAIL) begin
         src = pdfe_pkg::nibble_chips(word_ff[pdfe_pkg::WORD_W-1 -: 4]);
      end else if (nib_ff == pdfe_pkg::NIB_TAIL) begin
         src = '{chips: pdfe_pkg::TAIL_CHIPS, len: pdfe_pkg::CHIP_LEN_W'(pdfe_pkg::CHIP_W)};
      end else begin
         src = '{chips: '0, len: pdfe_pkg::CHIP_LEN_W'(pdfe_pkg::CHIP_W)};
      end
      if (need_fill) begin
         merged     = acc_ff | ({src.chips, 8'h00} >> cnt_ff);
         merged_cnt = cnt_ff + pdfe_pkg::ACC_CNT_W'(src.len);
      end else begin
         merged     = acc_ff;
         merged_cnt = cnt_ff;
      end
   end

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      word_in   = word_ff;
      nib_in    = nib_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      byte_out  = merged[pdfe_pkg::ACC_W-1 -: pdfe_pkg::BYTE_W];
      if (idx_ff < pdfe_pkg::IDX_W'(pdfe_pkg::PREAMBLE_BYTES)) begin
         byte_out = pdfe_pkg::preamble_byte(idx_ff[1:0]);
      end
      if (step) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff >= pdfe_pkg::IDX_W'(pdfe_pkg::PREAMBLE_BYTES)) begin
            acc_in = {merged[pdfe_pkg::ACC_W-pdfe_pkg::BYTE_W-1:0], 8'h00};
            cnt_in = merged_cnt - pdfe_pkg::ACC_CNT_W'(8);
            if (need_fill) begin
               if (nib_ff < pdfe_pkg::NIB_TAIL) begin
                  word_in = {word_ff[pdfe_pkg::WORD_W-5:0], 4'h0};
               end
               if (nib_ff != pdfe_pkg::NIB_DONE) begin
                  nib_in = nib_ff + 1'b1;
               end
            end
         end
         if (is_last) begin
            active_in = 1'b0;
         end
      end
      if (load) begin
         active_in = 1'b1;
         idx_in    = '0;
         word_in   = q_in.word;
         nib_in    = '0;
         acc_in    = '0;
         cnt_in    = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         nib_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         nib_ff       <= nib_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      acc_ff  <= acc_in;
      if (step) begin
         out_byte_ff <= byte_out;
         out_idx_ff  <= idx_ff;
         out_last_ff <= is_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_idx_ff, out_byte_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- hdl/pulse_distance_frame_encoder.sv -----
// channel | direction | tdata (low bit up)                  | tuser | tlast
// req_    | in        | pin [7:0], command [15:8]           | -     | -
// rsp_    | out       | frame_byte [7:0], byte_index [12:8] | -     | last byte of frame
//
// FRAME_BYTES bytes per request, one byte a cycle from the output register while rsp_tready is high.
// The first byte passes the queue, the sequencer load and the output
// register; a queued request follows the last byte of the previous frame with no gap.
// Synchronous reset clears queue, sequencer and output valid.
// A two-entry queue lets requests be taken while the response side stalls.
module pulse_distance_frame_encoder #(
   parameter int FRAME_BYTES = pdfe_pkg::FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // pin [7:0], command [15:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // frame_byte [7:0], byte_index [12:8], zero [15:13]
   output logic        rsp_tlast
);

   pdfe_pkg::word_req_type q;
   logic                   q_ready;

   pdfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_out      (q),
      .q_ready    (q_ready)
   );

   pdfe_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_in       (q),
      .q_ready    (q_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- hdl/pdfe_checker.sv -----
module pdfe_checker #(
   parameter int FRAME_BYTES = pdfe_pkg::FRAME_BYTES_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   localparam logic [4:0] LAST_IDX = 5'(FRAME_BYTES - 1);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[12:8] == LAST_IDX)))
      else $error("tlast does not match byte index");

   a_preamble: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[12:8] == 5'd0 || rsp_tdata[12:8] == 5'd1)
         |-> rsp_tdata[7:0] == 8'hFF)
      else $error("bad preamble byte");

   a_preamble_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12:8] == 5'd2 |-> rsp_tdata[7:0] == 8'h00)
      else $error("bad preamble gap byte");

   // sync byte opens with chips 10 1000 10
   a_sync_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12:8] == 5'd3
         |-> rsp_tdata[7:0] == 8'hA2 && rsp_tdata[15:13] == 3'd0)
      else $error("bad first sync byte");

endmodule

bind pulse_distance_frame_encoder pdfe_checker #(.FRAME_BYTES(FRAME_BYTES)) u_pdfe_checker (.*);
